// ===== design/deg_pkg.sv =====
package deg_pkg;

  localparam int LEVEL_FRAC_BITS = 24;
  localparam int FRAME_BITS = 24;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FRAMES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_FRAMES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FRAMES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_MODE      = 3'd7;

  // Item function codes.
  localparam int FUNC_W = 2;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

  localparam int STAGE_W = 3;

  typedef enum logic [STAGE_W-1:0] {
    ST_OFF     = 3'd0,
    ST_DELAY   = 3'd1,
    ST_ATTACK  = 3'd2,
    ST_HOLD    = 3'd3,
    ST_DECAY   = 3'd4,
    ST_SUSTAIN = 3'd5,
    ST_RELEASE = 3'd6
  } stage_t;

endpackage

// ===== design/deg_engine.sv =====
module deg_engine #(
  parameter int LEVEL_FRAC_BITS = deg_pkg::LEVEL_FRAC_BITS,
  parameter int FRAME_BITS = deg_pkg::FRAME_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic [deg_pkg::FUNC_W-1:0]        func,
  input  logic [FRAME_BITS-1:0]             release_frames,
  input  logic [LEVEL_FRAC_BITS:0]          release_rate,
  input  logic [FRAME_BITS-1:0]             delay_frames,
  input  logic [FRAME_BITS-1:0]             attack_frames,
  input  logic [LEVEL_FRAC_BITS:0]          attack_rate,
  input  logic [FRAME_BITS-1:0]             hold_frames,
  input  logic [FRAME_BITS-1:0]             decay_frames,
  input  logic [LEVEL_FRAC_BITS:0]          decay_rate,
  input  logic [LEVEL_FRAC_BITS:0]          sustain_level,
  input  logic                              log_mode,
  output logic [LEVEL_FRAC_BITS:0]          level,
  output logic [deg_pkg::STAGE_W-1:0]       stage,
  output logic                              ended
);

  localparam int LW = LEVEL_FRAC_BITS + 1;
  localparam logic [63:0] ONE64 = 64'd1 << LEVEL_FRAC_BITS;
  localparam logic [LW-1:0] ONE = LW'(ONE64);
  localparam logic [LW-1:0] LOG_FLOOR = LW'((ONE64 + 64'd50000) / 64'd100000);

  deg_pkg::stage_t         env_stage, env_stage_next;
  logic [LW-1:0]           env_level, env_level_next;
  logic [FRAME_BITS-1:0]   frames_left, frames_left_next;
  logic [LW-1:0]           env_step, env_step_next;
  logic                    ended_next;

  // Sustain register above full scale is used as full scale.
  logic [LW-1:0] sus;
  assign sus = (sustain_level > ONE) ? ONE : sustain_level;

  // Entry chain: each stage falls through to the next when its length is zero.
  deg_pkg::stage_t         ds_stage, hl_stage, at_stage, st_stage;
  logic [LW-1:0]           ds_level, hl_level, at_level, st_level;
  logic [LW-1:0]           ds_step, hl_step, at_step, st_step;
  logic [FRAME_BITS-1:0]   ds_left, hl_left, at_left, st_left;

  always_comb begin
    if (decay_frames != '0 && sus < ONE) begin
      ds_stage = deg_pkg::ST_DECAY;
      ds_level = ONE;
      ds_step  = decay_rate;
      ds_left  = decay_frames;
    end else begin
      ds_stage = deg_pkg::ST_SUSTAIN;
      ds_level = sus;
      ds_step  = '0;
      ds_left  = '0;
    end
    if (hold_frames != '0) begin
      hl_stage = deg_pkg::ST_HOLD;
      hl_level = ONE;
      hl_step  = '0;
      hl_left  = hold_frames;
    end else begin
      hl_stage = ds_stage;
      hl_level = ds_level;
      hl_step  = ds_step;
      hl_left  = ds_left;
    end
    if (attack_frames != '0) begin
      at_stage = deg_pkg::ST_ATTACK;
      at_level = '0;
      at_step  = attack_rate;
      at_left  = attack_frames;
    end else begin
      at_stage = hl_stage;
      at_level = hl_level;
      at_step  = hl_step;
      at_left  = hl_left;
    end
    if (delay_frames != '0) begin
      st_stage = deg_pkg::ST_DELAY;
      st_level = '0;
      st_step  = '0;
      st_left  = delay_frames;
    end else begin
      st_stage = at_stage;
      st_level = at_level;
      st_step  = at_step;
      st_left  = at_left;
    end
  end

  // Frame count-down shared by all timed stages.
  logic                  cd_done;
  logic [FRAME_BITS-1:0] cd_left;
  assign cd_done = (frames_left <= FRAME_BITS'(1));
  assign cd_left = cd_done ? '0 : frames_left - FRAME_BITS'(1);

  // Attack ramp with saturation at full scale.
  logic [LW:0]   att_sum;
  logic [LW-1:0] att_level;
  assign att_sum   = {1'b0, env_level} + {1'b0, env_step};
  assign att_level = (att_sum > {1'b0, ONE}) ? ONE : att_sum[LW-1:0];

  // Decay and release slope: multiply or subtract.
  logic [2*LW-1:0] prod;
  logic [2*LW-1:0] prod_sh;
  logic [LW-1:0]   slope_level;
  assign prod    = {{LW{1'b0}}, env_level} * {{LW{1'b0}}, env_step};
  assign prod_sh = prod >> LEVEL_FRAC_BITS;
  always_comb begin
    if (log_mode) begin
      slope_level = (prod_sh > {{LW{1'b0}}, ONE}) ? ONE : prod_sh[LW-1:0];
    end else begin
      slope_level = (env_level > env_step) ? env_level - env_step : '0;
    end
  end

  logic rel_done;
  assign rel_done = cd_done ||
                    (log_mode ? (slope_level <= LOG_FLOOR) : (slope_level == '0));

  always_comb begin
    env_stage_next   = env_stage;
    env_level_next   = env_level;
    frames_left_next = frames_left;
    env_step_next    = env_step;
    ended_next       = 1'b0;
    case (func)
      deg_pkg::FUNC_TICK: begin
        case (env_stage)
          deg_pkg::ST_DELAY: begin
            if (cd_done) begin
              env_stage_next   = at_stage;
              env_level_next   = at_level;
              env_step_next    = at_step;
              frames_left_next = at_left;
            end else begin
              frames_left_next = cd_left;
            end
          end
          deg_pkg::ST_ATTACK: begin
            if (cd_done) begin
              env_stage_next   = hl_stage;
              env_level_next   = hl_level;
              env_step_next    = hl_step;
              frames_left_next = hl_left;
            end else begin
              env_level_next   = att_level;
              frames_left_next = cd_left;
            end
          end
          deg_pkg::ST_HOLD: begin
            if (cd_done) begin
              env_stage_next   = ds_stage;
              env_level_next   = ds_level;
              env_step_next    = ds_step;
              frames_left_next = ds_left;
            end else begin
              frames_left_next = cd_left;
            end
          end
          deg_pkg::ST_DECAY: begin
            frames_left_next = cd_left;
            if (cd_done) begin
              env_stage_next = deg_pkg::ST_SUSTAIN;
              env_level_next = sus;
              env_step_next  = '0;
            end else begin
              env_level_next = slope_level;
            end
          end
          deg_pkg::ST_RELEASE: begin
            if (rel_done) begin
              env_stage_next   = deg_pkg::ST_OFF;
              env_level_next   = '0;
              env_step_next    = '0;
              frames_left_next = '0;
              ended_next       = 1'b1;
            end else begin
              env_level_next   = slope_level;
              frames_left_next = cd_left;
            end
          end
          default: begin
          end
        endcase
      end
      deg_pkg::FUNC_START: begin
        env_stage_next   = st_stage;
        env_level_next   = st_level;
        env_step_next    = st_step;
        frames_left_next = st_left;
      end
      deg_pkg::FUNC_RELEASE: begin
        if (env_stage != deg_pkg::ST_OFF) begin
          env_stage_next   = deg_pkg::ST_RELEASE;
          frames_left_next = (release_frames == '0) ? FRAME_BITS'(1) : release_frames;
          env_step_next    = release_rate;
        end
      end
      default: begin
      end
    endcase
  end

  // The state registers double as the result register: they only move when
  // the previous result has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      env_stage   <= deg_pkg::ST_OFF;
      env_level   <= '0;
      frames_left <= '0;
      env_step    <= '0;
      ended       <= 1'b0;
    end else if (en) begin
      env_stage   <= env_stage_next;
      env_level   <= env_level_next;
      frames_left <= frames_left_next;
      env_step    <= env_step_next;
      ended       <= ended_next;
    end
  end

  assign level = env_level;
  assign stage = env_stage;

`ifndef ASSERT_OFF
  a_ended_retired: assert property (@(posedge clk) disable iff (rst)
    ended |-> (env_stage == deg_pkg::ST_OFF) && (env_level == '0))
    else $error("ended set while voice still active");

  a_level_max: assert property (@(posedge clk) disable iff (rst)
    env_level <= ONE)
    else $error("envelope level above full scale");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(env_stage) && $stable(env_level) && $stable(ended))
    else $error("envelope state moved without a transaction");

  a_delay_silent: assert property (@(posedge clk) disable iff (rst)
    env_stage == deg_pkg::ST_DELAY |-> env_level == '0)
    else $error("nonzero level in delay stage");

  a_off_no_end: assert property (@(posedge clk) disable iff (rst)
    en && env_stage == deg_pkg::ST_OFF |=> !ended)
    else $error("inactive voice flagged as ended");
`endif

endmodule

// ===== design/dahdsr_envelope_generator_unit.sv =====
// Single-voice DAHDSR envelope. Each input transaction is a tick, a note start
// or a release; each produces exactly one output transaction carrying the level
// (unsigned, LEVEL_FRAC_BITS fractional bits, full scale is 1 << LEVEL_FRAC_BITS),
// the stage after the item and an ended flag. An accepted item waits in the input
// register and is applied to the envelope state registers, which double as the
// result register, once any previous result is taken. One item is accepted every
// cycle while the output side keeps taking results; the rate is set by the single
// envelope state update, which runs once per cycle behind the input register. The
// user must write the configuration registers through the cfg channel (always
// ready) only while no item is in flight; the block itself does not enforce this.
module dahdsr_envelope_generator_unit #(
  parameter int LEVEL_FRAC_BITS = deg_pkg::LEVEL_FRAC_BITS,
  parameter int FRAME_BITS = deg_pkg::FRAME_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // release_frames, release_rate, zero padding
  input  logic [((FRAME_BITS+LEVEL_FRAC_BITS+8)/8)*8-1:0] s_axis_tdata,
  // func
  input  logic [deg_pkg::FUNC_W-1:0]          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // level, zero padding
  output logic [((LEVEL_FRAC_BITS+8)/8)*8-1:0] m_axis_tdata,
  // stage, ended
  output logic [deg_pkg::STAGE_W:0]           m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [deg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [((FRAME_BITS > LEVEL_FRAC_BITS+1) ? FRAME_BITS : LEVEL_FRAC_BITS+1)-1:0]
                                              cfg_data
);

  localparam int LW = LEVEL_FRAC_BITS + 1;
  localparam int FW = FRAME_BITS;
  localparam int OUT_W = ((LEVEL_FRAC_BITS + 8) / 8) * 8;
  localparam logic [LW-1:0] ONE = LW'(1) << LEVEL_FRAC_BITS;

  // Configuration registers.
  logic [FW-1:0] delay_frames, attack_frames, hold_frames, decay_frames;
  logic [LW-1:0] attack_rate, decay_rate, sustain_level;
  logic          log_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_frames  <= '0;
      attack_frames <= '0;
      attack_rate   <= '0;
      hold_frames   <= '0;
      decay_frames  <= '0;
      decay_rate    <= '0;
      sustain_level <= ONE;
      log_mode      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        deg_pkg::CFG_DELAY_FRAMES:  delay_frames  <= cfg_data[FW-1:0];
        deg_pkg::CFG_ATTACK_FRAMES: attack_frames <= cfg_data[FW-1:0];
        deg_pkg::CFG_ATTACK_RATE:   attack_rate   <= cfg_data[LW-1:0];
        deg_pkg::CFG_HOLD_FRAMES:   hold_frames   <= cfg_data[FW-1:0];
        deg_pkg::CFG_DECAY_FRAMES:  decay_frames  <= cfg_data[FW-1:0];
        deg_pkg::CFG_DECAY_RATE:    decay_rate    <= cfg_data[LW-1:0];
        deg_pkg::CFG_SUSTAIN_LEVEL: sustain_level <= cfg_data[LW-1:0];
        deg_pkg::CFG_LOG_MODE:      log_mode      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  logic                        in_valid;
  logic [deg_pkg::FUNC_W-1:0]  in_func;
  logic [FW-1:0]               in_rel_frames;
  logic [LW-1:0]               in_rel_rate;
  logic                        out_valid;
  logic                        advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func       <= s_axis_tuser;
      in_rel_frames <= s_axis_tdata[FW-1:0];
      in_rel_rate   <= s_axis_tdata[FW+LW-1:FW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  logic [LW-1:0]                level;
  logic [deg_pkg::STAGE_W-1:0]  stage;
  logic                         ended;

  deg_engine #(
    .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS),
    .FRAME_BITS(FRAME_BITS)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .en(advance),
    .func(in_func),
    .release_frames(in_rel_frames),
    .release_rate(in_rel_rate),
    .delay_frames(delay_frames),
    .attack_frames(attack_frames),
    .attack_rate(attack_rate),
    .hold_frames(hold_frames),
    .decay_frames(decay_frames),
    .decay_rate(decay_rate),
    .sustain_level(sustain_level),
    .log_mode(log_mode),
    .level(level),
    .stage(stage),
    .ended(ended)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'(level);
  assign m_axis_tuser  = {ended, stage};

endmodule

// ===== dv/dahdsr_envelope_checker.sv =====
module dahdsr_envelope_checker #(
  parameter int IN_W  = ((deg_pkg::FRAME_BITS+deg_pkg::LEVEL_FRAC_BITS+8)/8)*8,
  parameter int OUT_W = ((deg_pkg::LEVEL_FRAC_BITS+8)/8)*8,
  parameter int CFG_W = (deg_pkg::FRAME_BITS > deg_pkg::LEVEL_FRAC_BITS+1) ?
                        deg_pkg::FRAME_BITS : deg_pkg::LEVEL_FRAC_BITS+1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [IN_W-1:0]               s_axis_tdata,
  input  logic [deg_pkg::FUNC_W-1:0]    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [OUT_W-1:0]              m_axis_tdata,
  input  logic [deg_pkg::STAGE_W:0]     m_axis_tuser,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [deg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  output int                            errors,
  output int                            pending,
  output int                            results,
  output int                            retired
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVEL_FRAC_BITS = deg_pkg::LEVEL_FRAC_BITS;
  localparam int FRAME_BITS = deg_pkg::FRAME_BITS;
  localparam int STAGE_W = deg_pkg::STAGE_W;
  localparam int LVL_W = LEVEL_FRAC_BITS + 1;
  localparam logic [LVL_W-1:0] FULL_SCALE = LVL_W'(1) << LEVEL_FRAC_BITS;
  // Logarithmic release stops once the level falls to about 1e-5 of full scale.
  localparam longint LOG_FLOOR = ((longint'(1) << LEVEL_FRAC_BITS) + 50000) / 100000;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    deg_pkg::stage_t  stage;
    logic             ended;
  } env_result_t;

  logic [FRAME_BITS-1:0] delay_len, attack_len, hold_len, decay_len;
  logic [LVL_W-1:0]      attack_inc, decay_coef, sustain_reg;
  logic                  log_curve;

  deg_pkg::stage_t       env_stage;
  logic [LVL_W-1:0]      env_level, env_step;
  logic [FRAME_BITS-1:0] frames_left;

  env_result_t           expected_q[$];

  function automatic logic [LVL_W-1:0] sat_full(logic [LVL_W+1:0] v);
    return (v > (LVL_W+2)'(FULL_SCALE)) ? FULL_SCALE : v[LVL_W-1:0];
  endfunction

  // Counts one frame and reports whether the current stage has run out.
  function automatic bit frame_expired();
    if (frames_left <= 1) begin
      frames_left = '0;
      return 1'b1;
    end
    frames_left = frames_left - 1'b1;
    return 1'b0;
  endfunction

  function automatic void slope_step();
    logic [2*LVL_W-1:0] prod;
    if (log_curve) begin
      prod = (2*LVL_W)'(env_level) * (2*LVL_W)'(env_step);
      env_level = sat_full((LVL_W+2)'(prod >> LEVEL_FRAC_BITS));
    end else begin
      env_level = (env_level > env_step) ? env_level - env_step : '0;
    end
  endfunction

  function automatic void enter_decay_or_sustain();
    logic [LVL_W-1:0] sus;
    sus = sat_full((LVL_W+2)'(sustain_reg));
    if (decay_len != 0 && sus < FULL_SCALE) begin
      env_stage = deg_pkg::ST_DECAY;
      frames_left = decay_len;
      env_step = decay_coef;
    end else begin
      env_level = sus;
      env_step = '0;
      frames_left = '0;
      env_stage = deg_pkg::ST_SUSTAIN;
    end
  endfunction

  function automatic void enter_hold_or_later();
    env_level = FULL_SCALE;
    env_step = '0;
    if (hold_len != 0) begin
      env_stage = deg_pkg::ST_HOLD;
      frames_left = hold_len;
    end else begin
      enter_decay_or_sustain();
    end
  endfunction

  function automatic void enter_attack_or_later();
    if (attack_len != 0) begin
      env_level = '0;
      env_step = attack_inc;
      frames_left = attack_len;
      env_stage = deg_pkg::ST_ATTACK;
    end else begin
      enter_hold_or_later();
    end
  endfunction

  function automatic bit advance_frame();
    bit done;
    case (env_stage)
      deg_pkg::ST_DELAY: begin
        if (frame_expired()) enter_attack_or_later();
      end
      deg_pkg::ST_ATTACK: begin
        env_level = sat_full((LVL_W+2)'(env_level) + (LVL_W+2)'(env_step));
        if (frame_expired()) enter_hold_or_later();
      end
      deg_pkg::ST_HOLD: begin
        if (frame_expired()) enter_decay_or_sustain();
      end
      deg_pkg::ST_DECAY: begin
        slope_step();
        if (frame_expired()) begin
          env_level = sat_full((LVL_W+2)'(sustain_reg));
          env_step = '0;
          env_stage = deg_pkg::ST_SUSTAIN;
        end
      end
      deg_pkg::ST_RELEASE: begin
        slope_step();
        done = frame_expired();
        if (log_curve ? (longint'(env_level) <= LOG_FLOOR) : (env_level == 0)) done = 1'b1;
        if (done) begin
          env_level = '0;
          env_step = '0;
          frames_left = '0;
          env_stage = deg_pkg::ST_OFF;
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic env_result_t envelope_after(logic [deg_pkg::FUNC_W-1:0] fn,
                                                 logic [FRAME_BITS-1:0] rel_len,
                                                 logic [LVL_W-1:0] rel_rate);
    env_result_t r;
    bit done;
    done = 1'b0;
    case (fn)
      deg_pkg::FUNC_TICK: done = advance_frame();
      deg_pkg::FUNC_START: begin
        if (delay_len != 0) begin
          env_stage = deg_pkg::ST_DELAY;
          env_level = '0;
          env_step = '0;
          frames_left = delay_len;
        end else begin
          enter_attack_or_later();
        end
      end
      deg_pkg::FUNC_RELEASE: begin
        if (env_stage != deg_pkg::ST_OFF) begin
          env_stage = deg_pkg::ST_RELEASE;
          frames_left = (rel_len == 0) ? FRAME_BITS'(1) : rel_len;
          env_step = rel_rate;
        end
      end
      default: ;
    endcase
    r.level = env_level;
    r.stage = env_stage;
    r.ended = done;
    return r;
  endfunction

  always @(posedge clk) begin
    env_result_t want, got;
    if (rst) begin
      delay_len = '0;
      attack_len = '0;
      attack_inc = '0;
      hold_len = '0;
      decay_len = '0;
      decay_coef = '0;
      sustain_reg = FULL_SCALE;
      log_curve = 1'b0;
      env_stage = deg_pkg::ST_OFF;
      env_level = '0;
      env_step = '0;
      frames_left = '0;
      expected_q.delete();
      errors = 0;
      results = 0;
      retired = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          deg_pkg::CFG_DELAY_FRAMES:  delay_len = cfg_data[FRAME_BITS-1:0];
          deg_pkg::CFG_ATTACK_FRAMES: attack_len = cfg_data[FRAME_BITS-1:0];
          deg_pkg::CFG_ATTACK_RATE:   attack_inc = cfg_data[LVL_W-1:0];
          deg_pkg::CFG_HOLD_FRAMES:   hold_len = cfg_data[FRAME_BITS-1:0];
          deg_pkg::CFG_DECAY_FRAMES:  decay_len = cfg_data[FRAME_BITS-1:0];
          deg_pkg::CFG_DECAY_RATE:    decay_coef = cfg_data[LVL_W-1:0];
          deg_pkg::CFG_SUSTAIN_LEVEL: sustain_reg = cfg_data[LVL_W-1:0];
          deg_pkg::CFG_LOG_MODE:      log_curve = cfg_data[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(envelope_after(s_axis_tuser, s_axis_tdata[FRAME_BITS-1:0],
                                            s_axis_tdata[FRAME_BITS +: LVL_W]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.level = m_axis_tdata[LVL_W-1:0];
        got.stage = deg_pkg::stage_t'(m_axis_tuser[STAGE_W-1:0]);
        got.ended = m_axis_tuser[STAGE_W];
        results++;
        if (got.ended === 1'b1) retired++;
        if (expected_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: output transaction with nothing expected: %s %0d %0d %0b",
                     $realtime, "level, stage, ended", got.level, got.stage, got.ended);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.level !== want.level || got.stage !== want.stage ||
              got.ended !== want.ended) begin
            if (errors < 10)
              $display("%0t: mismatch: expected level %0d stage %0d ended %0b, %s",
                       $realtime, want.level, want.stage, want.ended,
                       $sformatf("got level %0d stage %0d ended %0b",
                                 got.level, got.stage, got.ended));
            errors++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVEL_FRAC_BITS = deg_pkg::LEVEL_FRAC_BITS;
  localparam int FRAME_BITS = deg_pkg::FRAME_BITS;
  localparam int FUNC_W = deg_pkg::FUNC_W;
  localparam int STAGE_W = deg_pkg::STAGE_W;
  localparam int CFG_IDX_W = deg_pkg::CFG_IDX_W;
  localparam int IN_W  = ((FRAME_BITS+LEVEL_FRAC_BITS+8)/8)*8;
  localparam int OUT_W = ((LEVEL_FRAC_BITS+8)/8)*8;
  localparam int CFG_W = (FRAME_BITS > LEVEL_FRAC_BITS+1) ? FRAME_BITS : LEVEL_FRAC_BITS+1;
  localparam int LVL_W = LEVEL_FRAC_BITS + 1;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [LVL_W-1:0] FULL_SCALE = LVL_W'(1) << LEVEL_FRAC_BITS;
  localparam logic [LVL_W-1:0] RATE_MAX = '1;
  localparam logic [FRAME_BITS-1:0] LEN_MAX = '1;
  localparam int RANDOM_ITEMS = 850;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata;   // release_frames, release_rate, zero padding
  logic [FUNC_W-1:0]    s_axis_tuser;   // func
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;   // level, zero padding
  logic [STAGE_W:0]     m_axis_tuser;   // stage, ended
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int errors, pending, results, retired;
  int sent, settings;
  bit calm;
  bit log_sel;

  dahdsr_envelope_generator_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  dahdsr_envelope_checker envelope_check (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors),
    .pending(pending),
    .results(results),
    .retired(retired)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("dahdsr_envelope_generator_unit test failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Output side: stalls of random length between runs of ready.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk);
        m_axis_tready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      m_axis_tready = 1'b1;
      repeat ($urandom_range(0, 20)) @(negedge clk);
    end
  end

  task automatic send(logic [FUNC_W-1:0] fn, logic [FRAME_BITS-1:0] rel_len,
                      logic [LVL_W-1:0] rel_rate);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = fn;
    s_axis_tdata = IN_W'({rel_rate, rel_len});
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  // Waits until every expected result has come out and the pipeline is empty.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_envelope(logic [FRAME_BITS-1:0] dly, logic [FRAME_BITS-1:0] att,
                              logic [LVL_W-1:0] att_rate, logic [FRAME_BITS-1:0] hld,
                              logic [FRAME_BITS-1:0] dec, logic [LVL_W-1:0] dec_rate,
                              logic [LVL_W-1:0] sus, logic lg);
    drain();
    write_reg(deg_pkg::CFG_DELAY_FRAMES, CFG_W'(dly));
    write_reg(deg_pkg::CFG_ATTACK_FRAMES, CFG_W'(att));
    write_reg(deg_pkg::CFG_ATTACK_RATE, CFG_W'(att_rate));
    write_reg(deg_pkg::CFG_HOLD_FRAMES, CFG_W'(hld));
    write_reg(deg_pkg::CFG_DECAY_FRAMES, CFG_W'(dec));
    write_reg(deg_pkg::CFG_DECAY_RATE, CFG_W'(dec_rate));
    write_reg(deg_pkg::CFG_SUSTAIN_LEVEL, CFG_W'(sus));
    write_reg(deg_pkg::CFG_LOG_MODE, CFG_W'(lg));
    log_sel = lg;
    settings++;
  endtask

  function automatic logic [FRAME_BITS-1:0] rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 86) return FRAME_BITS'($urandom_range(1, 6));
    if (r < 93) return FRAME_BITS'($urandom_range(7, 30));
    if (r < 96) return LEN_MAX;
    return FRAME_BITS'($urandom());
  endfunction

  // Rates for decay and release; in log mode they are mostly multipliers from a quarter up to one.
  function automatic logic [LVL_W-1:0] rand_slope(bit lg);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return RATE_MAX;
    if (r < 18) return LVL_W'($urandom());
    if (lg) return LVL_W'($urandom_range(1 << (LEVEL_FRAC_BITS - 2), 1 << LEVEL_FRAC_BITS));
    return LVL_W'($urandom_range(0, 1 << (LEVEL_FRAC_BITS - 2)));
  endfunction

  function automatic logic [LVL_W-1:0] rand_attack_rate();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return FULL_SCALE;
    if (r < 80) return LVL_W'($urandom_range(1 << (LEVEL_FRAC_BITS - 3), 1 << LEVEL_FRAC_BITS));
    if (r < 88) return '0;
    return LVL_W'($urandom());
  endfunction

  function automatic logic [LVL_W-1:0] rand_sustain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 25) return FULL_SCALE;
    if (r < 35) return FULL_SCALE | LVL_W'($urandom());
    return LVL_W'($urandom_range(0, (1 << LEVEL_FRAC_BITS) - 1));
  endfunction

  function automatic logic [FRAME_BITS-1:0] rand_release_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 85) return FRAME_BITS'($urandom_range(1, 12));
    if (r < 92) return LEN_MAX;
    return FRAME_BITS'($urandom());
  endfunction

  task automatic send_noise();
    send(FUNC_W'($urandom_range(0, 3)), FRAME_BITS'($urandom()), LVL_W'($urandom()));
  endtask

  task automatic send_tick_or_noise();
    if ($urandom_range(0, 99) < 7) send_noise();
    else send(deg_pkg::FUNC_TICK, FRAME_BITS'($urandom()), LVL_W'($urandom()));
  endtask

  // One note: a start, some frames, a release and frames for it to die out.
  task automatic play_note();
    int n;
    calm = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 9) == 0) begin
      // Broken sequence: release or stray items before any start.
      repeat ($urandom_range(1, 4)) send_noise();
    end
    send(deg_pkg::FUNC_START, FRAME_BITS'($urandom()), LVL_W'($urandom()));
    n = $urandom_range(0, 24);
    repeat (n) send_tick_or_noise();
    if ($urandom_range(0, 9) == 0) send(deg_pkg::FUNC_START, '0, '0);
    send(deg_pkg::FUNC_RELEASE, rand_release_len(), rand_slope(log_sel));
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(0, 3)) send_tick_or_noise();
      send(deg_pkg::FUNC_RELEASE, rand_release_len(), rand_slope(log_sel));
    end
    n = $urandom_range(0, 18);
    repeat (n) send_tick_or_noise();
  endtask

  initial begin
    int target;
    bit lg;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = deg_pkg::FUNC_TICK;
    cfg_valid = 1'b0;
    cfg_index = deg_pkg::CFG_DELAY_FRAMES;
    cfg_data = '0;
    sent = 0;
    settings = 0;
    calm = 1'b0;
    log_sel = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Reset settings: everything zero and sustain at full scale.
    send(deg_pkg::FUNC_TICK, '0, '0);
    send(deg_pkg::FUNC_RELEASE, LEN_MAX, RATE_MAX);
    send(FUNC_UNUSED, LEN_MAX, RATE_MAX);
    send(deg_pkg::FUNC_START, '0, '0);
    send(deg_pkg::FUNC_TICK, '0, '0);
    send(deg_pkg::FUNC_RELEASE, '0, '0);
    send(deg_pkg::FUNC_TICK, '0, '0);

    // Attack increment of full scale over two frames reaches full scale and saturates there.
    set_envelope(FRAME_BITS'(1), FRAME_BITS'(2), FULL_SCALE, FRAME_BITS'(1), FRAME_BITS'(2),
                 LVL_W'(1 << (LEVEL_FRAC_BITS - 2)), LVL_W'(1 << (LEVEL_FRAC_BITS - 1)),
                 1'b0);
    send(deg_pkg::FUNC_START, '0, '0);
    repeat (6) send(deg_pkg::FUNC_TICK, '0, '0);
    send(deg_pkg::FUNC_START, '0, '0);
    send(deg_pkg::FUNC_TICK, '0, '0);
    send(deg_pkg::FUNC_RELEASE, LEN_MAX, LVL_W'(1 << (LEVEL_FRAC_BITS - 4)));
    send(deg_pkg::FUNC_RELEASE, LEN_MAX, RATE_MAX);
    send(deg_pkg::FUNC_TICK, '0, '0);

    // Log decay with a multiplier above one, then a release that hits the floor.
    set_envelope('0, '0, '0, '0, FRAME_BITS'(3), RATE_MAX,
                 LVL_W'(1 << (LEVEL_FRAC_BITS - 1)), 1'b1);
    send(deg_pkg::FUNC_START, '0, '0);
    send(deg_pkg::FUNC_TICK, '0, '0);
    send(deg_pkg::FUNC_RELEASE, FRAME_BITS'(8), '0);
    send(deg_pkg::FUNC_TICK, '0, '0);
    send(deg_pkg::FUNC_TICK, '0, '0);

    target = sent + RANDOM_ITEMS;

    // Extremes first: most fields at their top value, then all fields zero.
    set_envelope('0, LEN_MAX, RATE_MAX, LEN_MAX, LEN_MAX, RATE_MAX, RATE_MAX, 1'b1);
    repeat (2) play_note();
    set_envelope(LEN_MAX, LEN_MAX, FULL_SCALE, '0, '0, '0, FULL_SCALE, 1'b0);
    repeat (2) play_note();
    set_envelope('0, '0, '0, '0, '0, '0, '0, 1'b0);
    repeat (2) play_note();

    while (sent < target) begin
      lg = 1'($urandom_range(0, 1));
      set_envelope(rand_len(), rand_len(), rand_attack_rate(), rand_len(), rand_len(),
                   rand_slope(lg), rand_sustain(), lg);
      repeat ($urandom_range(2, 5)) play_note();
    end

    drain();
    $display("Drove %0d items across %0d register settings; checked %0d results.",
             sent, settings, results);
    $display("The voice retired %0d times, in both linear and logarithmic modes.", retired);
    if (errors == 0 && pending == 0) begin
      $display("dahdsr_envelope_generator_unit test passed");
    end else begin
      $display("dahdsr_envelope_generator_unit test failed");
    end
    $finish;
  end

endmodule
